### rtl/stl_pkg.sv
// Shared types, constants and character classes of the S-expression token lexer.
package stl_pkg;

  localparam int POS_W = 32;
  localparam int LEN_W = 16;
  localparam int KIND_W = 5;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0A;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_DQUOTE  = 8'h22;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_PRIME   = 8'h27;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_ONE     = 8'h31;
  localparam logic [7:0] CH_COLON   = 8'h3A;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_BAR     = 8'h7C;

  typedef enum logic [17:0] {
    M_IDLE    = 18'h00001,
    M_COMMENT = 18'h00002,
    M_SYM     = 18'h00004,
    M_KEYW    = 18'h00008,
    M_ZERO    = 18'h00010,
    M_NUM     = 18'h00020,
    M_BADZERO = 18'h00040,
    M_DOT     = 18'h00080,
    M_DEC     = 18'h00100,
    M_HASH    = 18'h00200,
    M_BIN     = 18'h00400,
    M_HEX     = 18'h00800,
    M_STR     = 18'h01000,
    M_STRQ    = 18'h02000,
    M_STRERR  = 18'h04000,
    M_QSYM    = 18'h08000,
    M_QBAR    = 18'h10000,
    M_QERR    = 18'h20000
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    K_LPAREN   = 5'd0,
    K_RPAREN   = 5'd1,
    K_NUMERAL  = 5'd2,
    K_DECIMAL  = 5'd3,
    K_BINARY   = 5'd4,
    K_HEX      = 5'd5,
    K_STRING   = 5'd6,
    K_SYMBOL   = 5'd7,
    K_KEYWORD  = 5'd8,
    K_END      = 5'd9,
    K_BADNUM   = 5'd10,
    K_BADCONST = 5'd11,
    K_STRBAD   = 5'd12,
    K_STREOF   = 5'd13,
    K_QBAD     = 5'd14,
    K_QEOF     = 5'd15,
    K_BADKW    = 5'd16,
    K_STRAY    = 5'd17
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] len;
    logic             last;
  } token_t;

  typedef struct packed {
    logic [1:0] n;
    token_t     tok0;
    token_t     tok1;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return is_digit(c) || (c inside {[8'h61:8'h66], [8'h41:8'h46]});
  endfunction

  function automatic logic is_print(input logic [7:0] c);
    return c inside {[8'h20:8'h7E]};
  endfunction

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
  endfunction

  function automatic logic is_simple(input logic [7:0] c);
    return is_digit(c) || is_alpha(c) ||
           (c inside {8'h7E, 8'h21, 8'h40, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h5F,
                      8'h2D, 8'h2B, 8'h3D, 8'h3C, 8'h3E, 8'h2E, 8'h3F, 8'h2F});
  endfunction

endpackage

### rtl/stl_scan.sv
// Scanner state and per-byte token logic of the S-expression token lexer.
module stl_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           fire,
  input  logic [7:0]     char_code,
  input  logic           end_of_input,
  output stl_pkg::push_t push
);
  import stl_pkg::*;

  typedef struct packed {
    mode_t mode;
    logic  start_tok;
    logic  emit;
    kind_t kind;
  } idle_t;

  typedef struct packed {
    logic  vld;
    kind_t kind;
  } pend_t;

  function automatic idle_t lex_idle(input logic [7:0] c);
    idle_t r;
    r.mode = M_IDLE;
    r.start_tok = 1'b0;
    r.emit = 1'b0;
    r.kind = K_STRAY;
    if (is_ws(c)) begin
      r.mode = M_IDLE;
    end else if (c == CH_SEMI) begin
      r.mode = M_COMMENT;
    end else if (c == CH_LPAREN) begin
      r.emit = 1'b1;
      r.kind = K_LPAREN;
    end else if (c == CH_RPAREN) begin
      r.emit = 1'b1;
      r.kind = K_RPAREN;
    end else if (c == CH_HASH) begin
      r.mode = M_HASH;
      r.start_tok = 1'b1;
    end else if (c == CH_DQUOTE) begin
      r.mode = M_STR;
      r.start_tok = 1'b1;
    end else if (c == CH_BAR) begin
      r.mode = M_QSYM;
      r.start_tok = 1'b1;
    end else if (c == CH_ZERO) begin
      r.mode = M_ZERO;
      r.start_tok = 1'b1;
    end else if (is_digit(c)) begin
      r.mode = M_NUM;
      r.start_tok = 1'b1;
    end else if (is_simple(c)) begin
      r.mode = M_SYM;
      r.start_tok = 1'b1;
    end else if (c == CH_COLON) begin
      r.mode = M_KEYW;
      r.start_tok = 1'b1;
    end else begin
      r.emit = 1'b1;
      r.kind = K_STRAY;
    end
    return r;
  endfunction

  function automatic pend_t pending_kind(input mode_t m, input logic [LEN_W-1:0] n);
    pend_t p;
    p.vld = 1'b1;
    p.kind = K_SYMBOL;
    case (m)
      M_SYM, M_QBAR:       p.kind = K_SYMBOL;
      M_KEYW:              p.kind = (n == LEN_W'(1)) ? K_BADKW : K_KEYWORD;
      M_ZERO, M_NUM:       p.kind = K_NUMERAL;
      M_BADZERO, M_DOT:    p.kind = K_BADNUM;
      M_DEC:               p.kind = K_DECIMAL;
      M_HASH:              p.kind = K_BADCONST;
      M_BIN:               p.kind = K_BINARY;
      M_HEX:               p.kind = K_HEX;
      M_STRQ:              p.kind = K_STRING;
      M_STR, M_STRERR:     p.kind = K_STREOF;
      M_QSYM, M_QERR:      p.kind = K_QEOF;
      default:             p.vld = 1'b0;
    endcase
    return p;
  endfunction

  mode_t            mode, mode_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] tstart, tstart_next;
  logic [LEN_W-1:0] cnt, cnt_next;
  logic [LEN_W-1:0] ext;
  logic             relex;
  logic             fin;
  kind_t            fin_kind;
  idle_t            li;
  pend_t            pk;
  logic             a_vld, b_vld;
  token_t           a_tok, b_tok;
  logic [7:0]       c;

  assign c   = char_code;
  assign ext = (cnt == LEN_MAX) ? cnt : cnt + LEN_W'(1);
  assign li  = lex_idle(c);
  assign pk  = pending_kind(mode, cnt);

  always_comb begin
    mode_next = mode;
    pos_next = pos;
    tstart_next = tstart;
    cnt_next = cnt;
    relex = 1'b0;
    fin = 1'b0;
    fin_kind = K_SYMBOL;
    if (!end_of_input) begin
      pos_next = pos + POS_W'(1);
      case (mode)
        M_COMMENT: begin
          if (c == CH_LF || c == CH_CR) mode_next = M_IDLE;
        end
        M_SYM: begin
          if (is_simple(c)) begin
            cnt_next = ext;
          end else if (c == CH_PRIME) begin
            fin = 1'b1;
            fin_kind = K_SYMBOL;
            mode_next = M_IDLE;
          end else begin
            relex = 1'b1;
          end
        end
        M_KEYW: begin
          if (is_simple(c)) cnt_next = ext;
          else relex = 1'b1;
        end
        M_ZERO: begin
          if (is_digit(c)) begin
            cnt_next = ext;
            mode_next = M_BADZERO;
          end else if (c == CH_DOT) begin
            cnt_next = ext;
            mode_next = M_DOT;
          end else begin
            relex = 1'b1;
          end
        end
        M_NUM: begin
          if (is_digit(c)) begin
            cnt_next = ext;
          end else if (c == CH_DOT) begin
            cnt_next = ext;
            mode_next = M_DOT;
          end else begin
            relex = 1'b1;
          end
        end
        M_BADZERO, M_DEC: begin
          if (is_digit(c)) cnt_next = ext;
          else relex = 1'b1;
        end
        M_DOT: begin
          if (is_digit(c)) begin
            cnt_next = ext;
            mode_next = M_DEC;
          end else begin
            relex = 1'b1;
          end
        end
        M_HASH: begin
          if (c == CH_LOWER_B) begin
            cnt_next = ext;
            mode_next = M_BIN;
          end else if (c == CH_LOWER_X) begin
            cnt_next = ext;
            mode_next = M_HEX;
          end else begin
            relex = 1'b1;
          end
        end
        M_BIN: begin
          if (c == CH_ZERO || c == CH_ONE) cnt_next = ext;
          else relex = 1'b1;
        end
        M_HEX: begin
          if (is_xdigit(c)) cnt_next = ext;
          else relex = 1'b1;
        end
        M_STR: begin
          cnt_next = ext;
          if (c == CH_DQUOTE) mode_next = M_STRQ;
          else if (!is_print(c) || c == CH_BSLASH) mode_next = M_STRERR;
        end
        M_STRQ: begin
          if (c == CH_DQUOTE) begin
            cnt_next = ext;
            mode_next = M_STR;
          end else begin
            relex = 1'b1;
          end
        end
        M_STRERR: begin
          cnt_next = ext;
          if (c == CH_DQUOTE) begin
            fin = 1'b1;
            fin_kind = K_STRBAD;
            mode_next = M_IDLE;
          end
        end
        M_QSYM: begin
          cnt_next = ext;
          if (c == CH_BAR) mode_next = M_QBAR;
          else if (!is_print(c) || c == CH_BSLASH) mode_next = M_QERR;
        end
        M_QBAR: begin
          if (c == CH_PRIME) begin
            fin = 1'b1;
            fin_kind = K_SYMBOL;
            mode_next = M_IDLE;
          end else begin
            relex = 1'b1;
          end
        end
        M_QERR: begin
          cnt_next = ext;
          if (c == CH_BAR) begin
            fin = 1'b1;
            fin_kind = K_QBAD;
            mode_next = M_IDLE;
          end
        end
        default: relex = 1'b1;
      endcase
      if (relex) begin
        mode_next = li.mode;
        if (li.start_tok) begin
          tstart_next = pos;
          cnt_next = LEN_W'(1);
        end
      end
    end else begin
      mode_next = M_IDLE;
    end
  end

  always_comb begin
    a_vld = fin || ((relex || end_of_input) && pk.vld);
    a_tok.kind = fin ? fin_kind : pk.kind;
    a_tok.start = tstart;
    a_tok.len = fin ? ext : cnt;
    a_tok.last = 1'b0;
    b_vld = end_of_input || (relex && li.emit);
    b_tok.kind = end_of_input ? K_END : li.kind;
    b_tok.start = pos;
    b_tok.len = end_of_input ? '0 : LEN_W'(1);
    b_tok.last = 1'b1;
  end

  always_comb begin
    push.n = fire ? (2'(a_vld) + 2'(b_vld)) : 2'd0;
    push.tok0 = a_vld ? a_tok : b_tok;
    push.tok0.last = !(a_vld && b_vld);
    push.tok1 = b_tok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pos <= '0;
      tstart <= '0;
      cnt <= '0;
    end else if (fire) begin
      mode <= mode_next;
      pos <= pos_next;
      tstart <= tstart_next;
      cnt <= cnt_next;
    end
  end

  a_eof_idle: assert property (@(posedge clk) disable iff (rst)
    (fire && end_of_input) |=> (mode == M_IDLE))
    else $error("scanner not idle after end of input");

  a_eof_result: assert property (@(posedge clk) disable iff (rst)
    (fire && end_of_input) |-> (push.n != 2'd0))
    else $error("end of input produced no token");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (fire && !end_of_input) |=> (pos == $past(pos) + POS_W'(1)))
    else $error("byte position did not advance");

endmodule

### rtl/stl_queue.sv
// Result queue of the S-expression token lexer: up to two writes, one read per cycle.
module stl_queue (
  input  logic            clk,
  input  logic            rst,
  input  stl_pkg::push_t  push,
  input  logic            pop,
  output stl_pkg::token_t head,
  output logic            not_empty,
  output logic            room
);
  import stl_pkg::*;

  token_t                 mem [QUEUE_DEPTH];
  logic [QUEUE_IDX_W-1:0] wr, rd;
  logic [QUEUE_CNT_W-1:0] count;

  assign head = mem[rd];
  assign not_empty = (count != '0);
  assign room = (count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem[wr] <= push.tok0;
    if (push.n == 2'd2) mem[wr + QUEUE_IDX_W'(1)] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr <= '0;
      rd <= '0;
      count <= '0;
    end else begin
      wr <= wr + QUEUE_IDX_W'(push.n);
      if (pop) rd <= rd + QUEUE_IDX_W'(1);
      count <= count + QUEUE_CNT_W'(push.n) - QUEUE_CNT_W'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("result queue overflow");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (push.n != 2'd0) |-> (count <= QUEUE_CNT_W'(QUEUE_DEPTH - 2)))
    else $error("push without room for two tokens");

  a_pop_data: assert property (@(posedge clk) disable iff (rst)
    pop |-> (count != '0))
    else $error("read from empty result queue");

endmodule

### rtl/sexpr_token_lexer.sv
// Top level of the S-expression token lexer: input register, scanner and result queue.
// A byte transferred into the input register is scanned once the result queue has room,
//   and its tokens then enter the result queue, whose head drives out_valid.
// Throughput: one byte per cycle while the queue has room; the output port moves one
//   token per cycle when not stalled, so two tokens from one byte leave in turn.
// Reset clears the scan mode, byte position, token start, length and result queue.
module sexpr_token_lexer (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  token_kind,
  output logic [31:0] start_offset,
  output logic [15:0] token_length,
  output logic        last
);
  import stl_pkg::*;

  logic       held;
  logic [7:0] held_char;
  logic       held_eof;
  logic       fire;
  logic       room;
  logic       pop;
  push_t      push;
  token_t     head;

  assign fire = held && room;
  assign in_stall = held && !room;
  assign pop = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held <= 1'b1;
    end else if (fire) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      held_char <= char_code;
      held_eof <= end_of_input;
    end
  end

  stl_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .char_code    (held_char),
    .end_of_input (held_eof),
    .push         (push)
  );

  stl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .head      (head),
    .not_empty (out_valid),
    .room      (room)
  );

  assign token_kind = head.kind;
  assign start_offset = head.start;
  assign token_length = head.len;
  assign last = head.last;

  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (held && !fire))
    else $error("stall without a waiting byte");

  a_stall_keep: assert property (@(posedge clk) disable iff (rst)
    in_stall |=> held)
    else $error("stalled byte dropped");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(token_kind) &&
      $stable(start_offset) && $stable(token_length) && $stable(last)))
    else $error("stalled token changed");

endmodule

### verif/sexpr_token_lexer_tb.sv
// Testbench for the S-expression token lexer: directed and random text against a token predictor.
module sexpr_token_lexer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import stl_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [31:0] start;
    logic [15:0] len;
    logic        last;
  } token_rec_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  char_code = 8'h00;
  logic        end_of_input = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  token_kind;
  logic [31:0] start_offset;
  logic [15:0] token_length;
  logic        last;

  sexpr_token_lexer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .char_code(char_code),
    .end_of_input(end_of_input),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .token_kind(token_kind),
    .start_offset(start_offset),
    .token_length(token_length),
    .last(last)
  );

  // Lexer state as predicted.
  mode_t       lex_mode = M_IDLE;
  logic [31:0] lex_pos = '0;
  logic [31:0] tok_start = '0;
  logic [15:0] tok_len = '0;

  token_rec_t  step_toks[$];
  token_rec_t  expected_tokens[$];
  logic [8:0]  text_q[$];
  int          mismatches = 0;
  int          stall_left = 0;
  bit          tx_idle = 1'b1;
  bit          rx_idle = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #30_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit digit_ch(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit letter_ch(logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic bit hexdig_ch(logic [7:0] c);
    return digit_ch(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic bit printable_ch(logic [7:0] c);
    return c >= 8'h20 && c <= 8'h7E;
  endfunction

  function automatic bit space_ch(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  function automatic bit symchar_ch(logic [7:0] c);
    if (digit_ch(c) || letter_ch(c)) return 1'b1;
    case (c)
      "~", "!", "@", "$", "%", "^", "&", "*", "_", "-", "+", "=", "<", ">", ".", "?", "/":
        return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic void push_token(kind_t k, logic [31:0] s, logic [15:0] n);
    token_rec_t t;
    t.kind = k;
    t.start = s;
    t.len = n;
    t.last = 1'b0;
    step_toks.push_back(t);
  endfunction

  function automatic void open_token(mode_t m);
    lex_mode = m;
    tok_start = lex_pos;
    tok_len = 16'd1;
  endfunction

  function automatic void grow_token();
    if (tok_len != '1) tok_len = tok_len + 16'd1;
  endfunction

  function automatic void close_token(kind_t k);
    push_token(k, tok_start, tok_len);
    lex_mode = M_IDLE;
  endfunction

  function automatic bit pending_kind(output kind_t k);
    k = K_END;
    case (lex_mode)
      M_SYM, M_QBAR: k = K_SYMBOL;
      M_KEYW: begin
        if (tok_len == 16'd1) k = K_BADKW;
        else k = K_KEYWORD;
      end
      M_ZERO, M_NUM: k = K_NUMERAL;
      M_BADZERO, M_DOT: k = K_BADNUM;
      M_DEC: k = K_DECIMAL;
      M_HASH: k = K_BADCONST;
      M_BIN: k = K_BINARY;
      M_HEX: k = K_HEX;
      M_STRQ: k = K_STRING;
      M_STR, M_STRERR: k = K_STREOF;
      M_QSYM, M_QERR: k = K_QEOF;
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void lex_fresh(logic [7:0] c);
    lex_mode = M_IDLE;
    if (space_ch(c)) return;
    if (c == CH_SEMI) lex_mode = M_COMMENT;
    else if (c == CH_LPAREN) push_token(K_LPAREN, lex_pos, 16'd1);
    else if (c == CH_RPAREN) push_token(K_RPAREN, lex_pos, 16'd1);
    else if (c == CH_HASH) open_token(M_HASH);
    else if (c == CH_DQUOTE) open_token(M_STR);
    else if (c == CH_BAR) open_token(M_QSYM);
    else if (c == CH_ZERO) open_token(M_ZERO);
    else if (digit_ch(c)) open_token(M_NUM);
    else if (symchar_ch(c)) open_token(M_SYM);
    else if (c == CH_COLON) open_token(M_KEYW);
    else push_token(K_STRAY, lex_pos, 16'd1);
  endfunction

  // Return 1 when c closes the pending token and must be lexed again.
  function automatic bit lex_cont(logic [7:0] c);
    case (lex_mode)
      M_COMMENT: begin
        if (c == CH_LF || c == CH_CR) lex_mode = M_IDLE;
        return 1'b0;
      end
      M_SYM: begin
        if (symchar_ch(c)) begin
          grow_token();
          return 1'b0;
        end
        if (c == CH_PRIME) begin
          grow_token();
          close_token(K_SYMBOL);
          return 1'b0;
        end
        return 1'b1;
      end
      M_KEYW: begin
        if (symchar_ch(c)) begin
          grow_token();
          return 1'b0;
        end
        return 1'b1;
      end
      M_ZERO, M_NUM: begin
        if (digit_ch(c)) begin
          grow_token();
          if (lex_mode == M_ZERO) lex_mode = M_BADZERO;
          return 1'b0;
        end
        if (c == CH_DOT) begin
          grow_token();
          lex_mode = M_DOT;
          return 1'b0;
        end
        return 1'b1;
      end
      M_BADZERO, M_DEC: begin
        if (digit_ch(c)) begin
          grow_token();
          return 1'b0;
        end
        return 1'b1;
      end
      M_DOT: begin
        if (digit_ch(c)) begin
          grow_token();
          lex_mode = M_DEC;
          return 1'b0;
        end
        return 1'b1;
      end
      M_HASH: begin
        if (c == CH_LOWER_B || c == CH_LOWER_X) begin
          grow_token();
          if (c == CH_LOWER_B) lex_mode = M_BIN;
          else lex_mode = M_HEX;
          return 1'b0;
        end
        return 1'b1;
      end
      M_BIN: begin
        if (c == CH_ZERO || c == CH_ONE) begin
          grow_token();
          return 1'b0;
        end
        return 1'b1;
      end
      M_HEX: begin
        if (hexdig_ch(c)) begin
          grow_token();
          return 1'b0;
        end
        return 1'b1;
      end
      M_STR: begin
        grow_token();
        if (c == CH_DQUOTE) lex_mode = M_STRQ;
        else if (!printable_ch(c) || c == CH_BSLASH) lex_mode = M_STRERR;
        return 1'b0;
      end
      M_STRQ: begin
        if (c == CH_DQUOTE) begin
          grow_token();
          lex_mode = M_STR;
          return 1'b0;
        end
        return 1'b1;
      end
      M_STRERR: begin
        grow_token();
        if (c == CH_DQUOTE) close_token(K_STRBAD);
        return 1'b0;
      end
      M_QSYM: begin
        grow_token();
        if (c == CH_BAR) lex_mode = M_QBAR;
        else if (!printable_ch(c) || c == CH_BSLASH) lex_mode = M_QERR;
        return 1'b0;
      end
      M_QBAR: begin
        if (c == CH_PRIME) begin
          grow_token();
          close_token(K_SYMBOL);
          return 1'b0;
        end
        return 1'b1;
      end
      M_QERR: begin
        grow_token();
        if (c == CH_BAR) close_token(K_QBAD);
        return 1'b0;
      end
      default: begin
        lex_fresh(c);
        return 1'b0;
      end
    endcase
  endfunction

  function automatic void lex_predict(logic [7:0] c, logic eoi);
    kind_t k;
    step_toks.delete();
    if (eoi) begin
      if (pending_kind(k)) push_token(k, tok_start, tok_len);
      push_token(K_END, lex_pos, 16'd0);
      lex_mode = M_IDLE;
    end else begin
      if (lex_cont(c)) begin
        if (pending_kind(k)) push_token(k, tok_start, tok_len);
        lex_fresh(c);
      end
      lex_pos = lex_pos + 32'd1;
    end
    if (step_toks.size() > 0) step_toks[step_toks.size()-1].last = 1'b1;
    foreach (step_toks[i]) expected_tokens.push_back(step_toks[i]);
  endfunction

  task automatic report_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endtask

  task automatic check_token();
    token_rec_t t;
    if (expected_tokens.size() == 0) begin
      report_error($sformatf("unexpected token: kind %0d start %0d len %0d last %0d",
                             token_kind, start_offset, token_length, last));
    end else begin
      t = expected_tokens.pop_front();
      if (token_kind !== t.kind || start_offset !== t.start ||
          token_length !== t.len || last !== t.last) begin
        report_error($sformatf({"token mismatch: expected kind %0d start %0d len %0d last %0d,",
                                " got kind %0d start %0d len %0d last %0d"},
                               t.kind, t.start, t.len, t.last,
                               token_kind, start_offset, token_length, last));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_token();
      stall_left = rx_idle ? $urandom_range(0, 4) : 0;
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Drive one transfer and predict its tokens once accepted.
  task automatic send_item(input logic [7:0] c, input logic eoi);
    int gap;
    gap = tx_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    end_of_input <= eoi;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lex_predict(c, eoi);
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eof();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_tokens.size() != 0);
  endtask

  function automatic void add_byte(logic [7:0] c);
    text_q.push_back({1'b0, c});
  endfunction

  function automatic logic [7:0] pick_digit();
    return CH_ZERO + 8'($urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] pick_simple();
    string punct = "~!@$%^&*_-+=<>.?/";
    case ($urandom_range(0, 3))
      0: return pick_digit();
      1: return 8'h61 + 8'($urandom_range(0, 25));
      2: return 8'h41 + 8'($urandom_range(0, 25));
      default: return punct[$urandom_range(0, punct.len() - 1)];
    endcase
  endfunction

  function automatic logic [7:0] pick_text_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h20, 8'h7E));
    if (c == CH_DQUOTE || c == CH_BSLASH || c == CH_BAR) c = 8'h61;
    return c;
  endfunction

  // Append the bytes of one random token or an end-of-input mark, mostly well formed.
  function automatic void gen_token();
    int n;
    logic [7:0] c;
    string hexch = "0123456789abcdefABCDEF";
    n = $urandom_range(0, 6);
    case ($urandom_range(0, 19))
      0, 1: begin
        case ($urandom_range(0, 3))
          0: add_byte(CH_SPACE);
          1: add_byte(CH_TAB);
          2: add_byte(CH_LF);
          default: add_byte(CH_CR);
        endcase
      end
      2: begin
        add_byte(CH_SEMI);
        repeat (n) begin
          c = 8'($urandom_range(0, 255));
          if (c == CH_LF || c == CH_CR) c = CH_SPACE;
          add_byte(c);
        end
        add_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
      end
      3: add_byte(CH_LPAREN);
      4: add_byte(CH_RPAREN);
      5, 6: begin
        add_byte(pick_digit());
        repeat (n) add_byte(pick_digit());
      end
      7: begin
        add_byte(pick_digit());
        repeat (n % 3) add_byte(pick_digit());
        add_byte(CH_DOT);
        repeat ($urandom_range(0, 3)) add_byte(pick_digit());
      end
      8: begin
        add_byte(CH_HASH);
        add_byte(CH_LOWER_B);
        repeat (n) add_byte(CH_ZERO + 8'($urandom_range(0, 1)));
      end
      9: begin
        add_byte(CH_HASH);
        add_byte(CH_LOWER_X);
        repeat (n) add_byte(hexch[$urandom_range(0, hexch.len() - 1)]);
      end
      10: begin
        add_byte(CH_HASH);
        add_byte(8'($urandom_range(0, 255)));
      end
      11, 12: begin
        add_byte(CH_DQUOTE);
        repeat (n) begin
          case ($urandom_range(0, 9))
            0: begin
              add_byte(CH_DQUOTE);
              add_byte(CH_DQUOTE);
            end
            1: add_byte(8'($urandom_range(0, 255)));
            default: add_byte(pick_text_char());
          endcase
        end
        if ($urandom_range(0, 9) != 0) add_byte(CH_DQUOTE);
      end
      13: begin
        add_byte(CH_BAR);
        repeat (n) begin
          if ($urandom_range(0, 9) == 0) add_byte(8'($urandom_range(0, 255)));
          else add_byte(pick_text_char());
        end
        if ($urandom_range(0, 9) != 0) add_byte(CH_BAR);
        if ($urandom_range(0, 3) == 0) add_byte(CH_PRIME);
      end
      14, 15: begin
        add_byte(8'h61 + 8'($urandom_range(0, 25)));
        repeat (n) add_byte(pick_simple());
        if ($urandom_range(0, 3) == 0) add_byte(CH_PRIME);
      end
      16: begin
        add_byte(CH_COLON);
        repeat (n % 4) add_byte(pick_simple());
      end
      17: add_byte(8'($urandom_range(0, 255)));
      18: text_q.push_back({1'b1, 8'($urandom_range(0, 255))});
      default: add_byte(8'($urandom_range(8'h80, 8'hFF)));
    endcase
  endfunction

  task automatic test_token_kinds();
    send_str("(07#b1#xA)#");
    send_item(8'hFF, 1'b0);
  endtask

  task automatic test_bad_tokens();
    send_str("|\\|:\"");
    send_item(8'h00, 1'b0);
    send_str("\"4.;");
    send_item(CH_LF, 1'b0);
    send_str("|q|'");
  endtask

  task automatic test_end_marks();
    send_eof();
    send_str("\"");
    send_eof();
    send_eof();
  endtask

  task automatic test_random_text(input int n_items);
    int sent;
    sent = 0;
    while (sent < n_items) begin
      text_q.delete();
      gen_token();
      if ($urandom_range(0, 24) == 0) tx_idle = ~tx_idle;
      if ($urandom_range(0, 24) == 0) rx_idle = ~rx_idle;
      foreach (text_q[i]) send_item(text_q[i][7:0], text_q[i][8]);
      sent += text_q.size();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_token_kinds();
    test_bad_tokens();
    test_end_marks();
    test_random_text(700);
    hold_until_drained();
    test_random_text(650);
    hold_until_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_tokens.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
